// ===== rtl/core/crfs_pkg.sv =====
// Shared types and constants for the composite record field splitter.
// No dependencies; imported by composite_record_field_splitter.
`default_nettype none

package crfs_pkg;

   localparam int unsigned MAX_COLUMNS = 64;
   localparam int unsigned COL_W       = 7;   // holds 0..MAX_COLUMNS
   localparam int unsigned IDX_W       = 6;   // column index on the result side

   // Special text bytes
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_CLOSE     = 8'h29;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_END   = 2'd1,
      KIND_NULL  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic {
      ST_INPUT = 1'b0,   // taking text bytes
      ST_BURST = 1'b1    // sending trailing null columns after ')'
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/composite_record_field_splitter.sv =====
// Composite record field splitter: top level, parser, null burst sequencer.
// Depends on crfs_pkg.
`default_nettype none

// Channel  | Dir | Signals                         | Content
// ---------+-----+---------------------------------+---------------------------------
// req      | in  | req_tvalid/tready/tdata/tuser   | text byte, new_record flag
// rsp      | out | rsp_tvalid/tready/tdata/tuser/  | value byte, column, kind,
//          |     | tlast                           | record_done
// csr      | in  | csr_wr_en/csr_wr_data           | column_count
//
// Cycles: one text byte per cycle while the result register drains and no null
//   burst runs. A ')' closing a record early is followed by a null per remaining
//   column (up to 63), driven by the column incrementer/compare shared with the parser.
// Reset: synchronous, active high; clears parser state, sequencer and rsp_tvalid.
// Stalls: a held result (rsp_tready low) holds off req_tready; a byte that
//   gives no result still needs the result register free to be taken.

module composite_record_field_splitter
   import crfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // text input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   input  wire logic        req_tuser,   // [0] new_record
   // results
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] value_byte, [13:8] column_index, [15:14] zero
   output logic [1:0]       rsp_tuser,   // [1:0] item_kind
   output logic             rsp_tlast,   // record_done
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data  // column_count
);

   // ---------------- state ----------------
   state_type          state_ff, state_in;
   logic [COL_W-1:0]   cfg_cols_ff;
   logic [COL_W-1:0]   rec_cols_ff, rec_cols_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               phase_ff, phase_in;
   logic               inq_ff, inq_in;
   logic               qpend_ff, qpend_in;
   logic               esc_ff, esc_in;
   logic               started_ff, started_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic [IDX_W-1:0]   rsp_col_ff, rsp_col_in;
   logic               rsp_done_ff, rsp_done_in;

   // ---------------- shared column unit ----------------
   // Increment and last-column compare, used for ',' / ')' and the null burst.
   logic [COL_W-1:0]   col_plus;
   logic               col_last;
   assign col_plus = col_ff + COL_W'(1);
   assign col_last = (col_plus >= rec_cols_ff);

   logic out_free;
   logic req_xfer;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_xfer = req_tvalid && req_tready;

   // ---------------- parser step ----------------
   logic               emit;
   kind_type           emit_kind;
   logic [7:0]         emit_byte;
   logic               emit_done;
   logic               burst_go;
   logic [7:0]         b;
   logic [COL_W-1:0]   cfg_clip;

   assign b        = req_tdata;
   assign cfg_clip = (cfg_cols_ff > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : cfg_cols_ff;

   always_comb begin
      logic eff_inq;
      logic do_unquoted;
      phase_in    = phase_ff;
      inq_in      = inq_ff;
      qpend_in    = qpend_ff;
      esc_in      = esc_ff;
      started_in  = started_ff;
      rec_cols_in = rec_cols_ff;
      col_in      = col_ff;
      emit        = 1'b0;
      emit_kind   = KIND_BYTE;
      emit_byte   = b;
      emit_done   = 1'b0;
      burst_go    = 1'b0;
      eff_inq     = inq_ff;
      do_unquoted = 1'b0;

      if (state_ff == ST_BURST) begin
         // one trailing null column per step
         if (out_free) begin
            emit      = 1'b1;
            emit_kind = KIND_NULL;
            emit_done = col_last;
            col_in    = col_plus;
         end
      end else if (req_xfer) begin
         priority if (req_tuser) begin
            rec_cols_in = cfg_clip;
            phase_in    = (cfg_clip != '0);
            inq_in      = 1'b0;
            qpend_in    = 1'b0;
            esc_in      = 1'b0;
            started_in  = 1'b0;
            col_in      = '0;
         end else if (!phase_ff || (col_ff >= rec_cols_ff)) begin
            phase_in = 1'b0;
         end else if (esc_ff) begin
            esc_in = 1'b0;
            emit   = 1'b1;
            if (b == CHAR_NUL) begin
               emit_kind = KIND_ERROR;
               emit_done = 1'b1;
               phase_in  = 1'b0;
            end else begin
               started_in = 1'b1;
            end
         end else begin
            if (qpend_ff) begin
               qpend_in = 1'b0;
               eff_inq  = 1'b0;
            end
            priority if (qpend_ff && (b == CHAR_QUOTE)) begin
               // doubled quote inside quotes
               emit       = 1'b1;
               started_in = 1'b1;
            end else if (qpend_ff) begin
               inq_in      = 1'b0;
               do_unquoted = 1'b1;
            end else if (eff_inq) begin
               priority if (b == CHAR_NUL) begin
                  emit      = 1'b1;
                  emit_kind = KIND_ERROR;
                  emit_done = 1'b1;
                  phase_in  = 1'b0;
               end else if (b == CHAR_BACKSLASH) begin
                  esc_in = 1'b1;
               end else if (b == CHAR_QUOTE) begin
                  qpend_in = 1'b1;
               end else begin
                  emit       = 1'b1;
                  started_in = 1'b1;
               end
            end else begin
               do_unquoted = 1'b1;
            end

            if (do_unquoted) begin
               priority if (b == CHAR_NUL) begin
                  emit      = 1'b1;
                  emit_kind = KIND_ERROR;
                  emit_done = 1'b1;
                  phase_in  = 1'b0;
               end else if ((b == CHAR_COMMA) || (b == CHAR_CLOSE)) begin
                  emit       = 1'b1;
                  emit_kind  = started_ff ? KIND_END : KIND_NULL;
                  emit_done  = col_last;
                  col_in     = col_plus;
                  started_in = 1'b0;
                  if (col_last || (b == CHAR_CLOSE)) phase_in = 1'b0;
                  // ')' with columns left: nulls follow
                  burst_go = (b == CHAR_CLOSE) && !col_last;
               end else if (b == CHAR_BACKSLASH) begin
                  esc_in     = 1'b1;
                  started_in = 1'b1;
               end else if (b == CHAR_QUOTE) begin
                  inq_in     = 1'b1;
                  started_in = 1'b1;
               end else begin
                  emit       = 1'b1;
                  started_in = 1'b1;
               end
            end
         end
      end
   end

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INPUT: if (burst_go) state_in = ST_BURST;
         ST_BURST: if (out_free && col_last) state_in = ST_INPUT;
         default:  state_in = ST_INPUT;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_tready   = (state_ff == ST_INPUT) && out_free;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_done_in  = rsp_done_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_byte_in  = (emit_kind == KIND_BYTE) ? emit_byte : 8'h00;
         rsp_col_in   = col_ff[IDX_W-1:0];
         rsp_done_in  = emit_done;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INPUT;
         cfg_cols_ff  <= '0;
         rec_cols_ff  <= '0;
         col_ff       <= '0;
         phase_ff     <= 1'b0;
         inq_ff       <= 1'b0;
         qpend_ff     <= 1'b0;
         esc_ff       <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) cfg_cols_ff <= csr_wr_data;
         rec_cols_ff  <= rec_cols_in;
         col_ff       <= col_in;
         phase_ff     <= phase_in;
         inq_ff       <= inq_in;
         qpend_ff     <= qpend_in;
         esc_ff       <= esc_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_col_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_done_ff;

`ifndef SYNTHESIS
   // burst runs only after the record has been closed
   a_burst_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BURST) |-> !phase_ff)
      else $error("null burst while record still parsing");

   // burst column stays inside the record
   a_burst_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BURST) |-> (col_ff < rec_cols_ff))
      else $error("null burst column out of range");

   // value bytes never end a record, errors always do
   a_byte_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_BYTE)) |-> !rsp_done_ff)
      else $error("value byte flagged as record end");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_ERROR)) |-> rsp_done_ff)
      else $error("error result without record end");

   // the last burst null closes the record
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_BURST) && out_free && col_last) |=> (rsp_valid_ff && rsp_done_ff))
      else $error("null burst ended without record end");
`endif

endmodule

`default_nettype wire
